FILE: hdl/gff_pkg.sv
// Package with the command codes, field widths and default sizes of the grid flood fill unit.
`timescale 1ns / 1ps

package gff_pkg;

    localparam int CMD_W   = 2;
    localparam int COORD_W = 4;
    localparam int IN_CLR_W  = 4;
    localparam int OUT_CLR_W = 4;

    // Widest color the grid may hold; it bounds the COLOR_BITS parameter.
    localparam int CLR_EXT_W = 8;

    localparam int DEF_GRID_ROWS    = 16;
    localparam int DEF_GRID_COLUMNS = 10;
    localparam int DEF_COLOR_BITS   = 4;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_WRITE = 2'd0;
    localparam t_cmd CMD_FILL  = 2'd1;
    localparam t_cmd CMD_READ  = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_coord;

endpackage

FILE: hdl/grid_flood_fill_unit.sv
// Top level of the grid flood fill unit: grid memory, worklist memory and fill sequencer.
//
//   Channel  Direction  Handshake               Payload
//   in       request    i_in_valid/o_in_stall   i_command, i_row, i_column, i_new_color
//   out      result     o_out_valid/i_out_stall o_read_color, o_fill_applied
//
// A write, an unused command or a request outside the grid goes straight to its result.
// A read, or a fill whose start cell already holds the new color, first waits on the grid read.
// Any other fill visits the four neighbours of every recolored cell through the single read ports.
// Reset clears every cell to color zero at once through a valid bit per cell.
// A result that waits on i_out_stall holds the sequencer, but the next request is
// taken as soon as the previous one has moved its result into the output register.
`timescale 1ns / 1ps

module grid_flood_fill_unit #(
    parameter int GRID_ROWS    = gff_pkg::DEF_GRID_ROWS,
    parameter int GRID_COLUMNS = gff_pkg::DEF_GRID_COLUMNS,
    parameter int COLOR_BITS   = gff_pkg::DEF_COLOR_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [gff_pkg::CMD_W-1:0]     i_command,
    input  logic [gff_pkg::COORD_W-1:0]   i_row,
    input  logic [gff_pkg::COORD_W-1:0]   i_column,
    input  logic [gff_pkg::IN_CLR_W-1:0]  i_new_color,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [gff_pkg::OUT_CLR_W-1:0] o_read_color,
    output logic                          o_fill_applied
);
    import gff_pkg::*;

    localparam int CELL_COUNT = GRID_ROWS * GRID_COLUMNS;
    localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int NB_W       = COORD_W + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_POP    = 3'd2;
    localparam logic [2:0] S_NEIGH  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam logic [2:0] NB_LAST = 3'd4;

    logic [2:0]            r_state, n_state;
    t_cmd                  r_cmd, n_cmd;
    logic [COLOR_BITS-1:0] r_fg, n_fg;
    logic [COLOR_BITS-1:0] r_bg, n_bg;
    t_coord                r_start, n_start;
    t_coord                r_cur, n_cur;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [2:0]            r_k, n_k;
    logic                  r_nb_ok, n_nb_ok;
    logic [ADDR_W-1:0]     r_nb_addr, n_nb_addr;
    t_coord                r_nb_rc, n_nb_rc;
    logic [OUT_CLR_W-1:0]  r_res_color, n_res_color;
    logic                  r_res_applied, n_res_applied;
    logic                  r_out_vld;
    logic [OUT_CLR_W-1:0]  r_out_color;
    logic                  r_out_applied;

    logic [COLOR_BITS-1:0] r_grid [CELL_COUNT];
    logic [CELL_COUNT-1:0] r_cell_vld;
    logic [COLOR_BITS-1:0] r_grid_q;
    logic                  r_vld_q;
    t_coord                r_stack [CELL_COUNT];
    t_coord                r_stk_q;

    logic                  grid_we;
    logic [ADDR_W-1:0]     grid_waddr;
    logic [ADDR_W-1:0]     grid_raddr;
    logic                  stk_we;
    logic [ADDR_W-1:0]     stk_waddr;
    t_coord                stk_wdata;
    logic [ADDR_W-1:0]     stk_raddr;

    logic                  in_accept;
    logic                  in_inside;
    logic [ADDR_W-1:0]     in_addr;
    logic [CLR_EXT_W-1:0]  in_color_ext;
    logic [COLOR_BITS-1:0] in_color;
    logic [COLOR_BITS-1:0] cell_q;
    logic [CLR_EXT_W-1:0]  cell_ext;
    logic                  out_free;
    t_coord                cur_rc;
    logic [NB_W-1:0]       nb_row;
    logic [NB_W-1:0]       nb_col;
    logic                  nb_ok;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign in_inside    = (32'(i_row) < GRID_ROWS) && (32'(i_column) < GRID_COLUMNS);
    assign in_addr      = in_inside ? ADDR_W'(32'(i_row) * GRID_COLUMNS + 32'(i_column))
                                    : '0;
    assign in_color_ext = CLR_EXT_W'(i_new_color);
    assign in_color     = in_color_ext[COLOR_BITS-1:0];
    assign cell_q       = r_vld_q ? r_grid_q : '0;
    assign cell_ext     = CLR_EXT_W'(cell_q);
    assign out_free     = !r_out_vld || !i_out_stall;
    assign cur_rc       = (r_k == 3'd0) ? r_stk_q : r_cur;

    always_comb begin
        nb_row = NB_W'(cur_rc.row);
        nb_col = NB_W'(cur_rc.col);
        nb_ok  = 1'b0;
        unique case (r_k)
            3'd0: begin
                nb_row = NB_W'(cur_rc.row) - NB_W'(1);
                nb_ok  = (cur_rc.row != '0);
            end
            3'd1: begin
                nb_row = NB_W'(cur_rc.row) + NB_W'(1);
                nb_ok  = (32'(nb_row) < GRID_ROWS);
            end
            3'd2: begin
                nb_col = NB_W'(cur_rc.col) - NB_W'(1);
                nb_ok  = (cur_rc.col != '0);
            end
            3'd3: begin
                nb_col = NB_W'(cur_rc.col) + NB_W'(1);
                nb_ok  = (32'(nb_col) < GRID_COLUMNS);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_fg          = r_fg;
        n_bg          = r_bg;
        n_start       = r_start;
        n_cur         = r_cur;
        n_cnt         = r_cnt;
        n_k           = r_k;
        n_nb_ok       = r_nb_ok;
        n_nb_addr     = r_nb_addr;
        n_nb_rc       = r_nb_rc;
        n_res_color   = r_res_color;
        n_res_applied = r_res_applied;
        grid_we       = 1'b0;
        grid_waddr    = r_nb_addr;
        grid_raddr    = in_addr;
        stk_we        = 1'b0;
        stk_waddr     = r_cnt[ADDR_W-1:0];
        stk_wdata     = r_nb_rc;
        stk_raddr     = r_cnt[ADDR_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_cmd         = i_command;
                    n_fg          = in_color;
                    n_start.row   = i_row;
                    n_start.col   = i_column;
                    n_nb_addr     = in_addr;
                    n_res_color   = '0;
                    n_res_applied = 1'b0;
                    if (i_command == CMD_WRITE) begin
                        grid_we    = in_inside;
                        grid_waddr = in_addr;
                        n_state    = S_DONE;
                    end else if ((i_command == CMD_READ || i_command == CMD_FILL)
                                 && in_inside) begin
                        n_state = S_RDWAIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RDWAIT: begin
                if (r_cmd == CMD_READ) begin
                    n_res_color = cell_ext[OUT_CLR_W-1:0];
                    n_state     = S_DONE;
                end else if (cell_q == r_fg) begin
                    n_state = S_DONE;
                end else begin
                    n_bg       = cell_q;
                    grid_we    = 1'b1;
                    grid_waddr = r_nb_addr;
                    stk_we     = 1'b1;
                    stk_waddr  = '0;
                    stk_wdata  = r_start;
                    n_cnt      = CNT_W'(1);
                    n_state    = S_POP;
                end
            end
            S_POP: begin
                if (r_cnt == '0) begin
                    n_res_applied = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    stk_raddr = ADDR_W'(r_cnt - CNT_W'(1));
                    n_cnt     = r_cnt - CNT_W'(1);
                    n_k       = 3'd0;
                    n_state   = S_NEIGH;
                end
            end
            S_NEIGH: begin
                n_cur      = cur_rc;
                n_nb_ok    = nb_ok;
                n_nb_rc    = '{row: nb_row[COORD_W-1:0], col: nb_col[COORD_W-1:0]};
                n_nb_addr  = nb_ok ? ADDR_W'(32'(nb_row) * GRID_COLUMNS + 32'(nb_col))
                                   : '0;
                grid_raddr = n_nb_addr;
                if (r_k != 3'd0 && r_nb_ok && cell_q == r_bg) begin
                    grid_we = 1'b1;
                    stk_we  = 1'b1;
                    n_cnt   = r_cnt + CNT_W'(1);
                end
                n_k = r_k + 3'd1;
                if (r_k == NB_LAST) begin
                    n_state = S_POP;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_k       <= '0;
            r_nb_ok   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_nb_ok <= n_nb_ok;
            if (r_state == S_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd         <= n_cmd;
        r_fg          <= n_fg;
        r_bg          <= n_bg;
        r_start       <= n_start;
        r_cur         <= n_cur;
        r_nb_addr     <= n_nb_addr;
        r_nb_rc       <= n_nb_rc;
        r_res_color   <= n_res_color;
        r_res_applied <= n_res_applied;
        if (r_state == S_DONE && out_free) begin
            r_out_color   <= r_res_color;
            r_out_applied <= r_res_applied;
        end
    end

    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            r_grid[grid_waddr] <= (r_state == S_IDLE) ? in_color : r_fg;
        end
        r_grid_q <= r_grid[grid_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_vld <= '0;
            r_vld_q    <= 1'b0;
        end else begin
            if (grid_we) begin
                r_cell_vld[grid_waddr] <= 1'b1;
            end
            r_vld_q <= r_cell_vld[grid_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_waddr] <= stk_wdata;
        end
        r_stk_q <= r_stack[stk_raddr];
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_read_color   = r_out_color;
    assign o_fill_applied = r_out_applied;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= CELL_COUNT)
        else $error("Worklist count exceeds the cell count.");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_we |-> 32'(r_cnt) < CELL_COUNT)
        else $error("Worklist push while the list is full.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("Request accepted without the sequencer leaving idle.");

    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fill_applied) |-> (o_read_color == '0))
        else $error("Fill result carries a read color.");

endmodule
